### design/assert_macros.svh
// assertion macros used by the port level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define QTR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// expression must never be true at a rising clock edge outside reset
`define QTR_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

### design/qtr_pkg.sv
// types, constants and helpers of the quad to rectangle warp core
package qtr_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int CW    = 9;   // coordinate width
  localparam int DW    = 10;  // image dimension width
  localparam int PW    = 20;  // area and coordinate product width
  localparam int SDW   = 10;  // signed corner difference width
  localparam int NW    = 32;  // signed numerator width
  localparam int QW    = 11;  // quotient bits, numerator stays below 2048 times the area
  localparam int CORNER_W = 18;
  localparam int RGB_W = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DW-1:0] DIM_RESET = 10'd512;

  localparam logic [2:0] CFG_CORNER_A     = 3'd0;
  localparam logic [2:0] CFG_CORNER_B     = 3'd1;
  localparam logic [2:0] CFG_CORNER_C     = 3'd2;
  localparam logic [2:0] CFG_CORNER_D     = 3'd3;
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] TRI_NONE = 2'd0;
  localparam logic [1:0] TRI_ONE  = 2'd1;
  localparam logic [1:0] TRI_TWO  = 2'd2;

  typedef struct packed {
    logic          opcode;
    logic [CW-1:0] pixel_x;
    logic [CW-1:0] pixel_y;
    logic [7:0]    red_in;
    logic [7:0]    green_in;
    logic [7:0]    blue_in;
  } qtr_req_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [1:0] which_triangle;
  } qtr_res_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic                  is_wr;
    logic                  wr_en;
    logic [1:0]            tri_sel;
    logic [CW-1:0]         wr_x;
    logic [CW-1:0]         wr_y;
    logic [RGB_W-1:0]      rgb;
    logic [PW-1:0]         mul_a;
    logic [PW-1:0]         mul_b;
    logic [CW-1:0]         base_x;
    logic [CW-1:0]         base_y;
    logic signed [SDW-1:0] da_x;
    logic signed [SDW-1:0] db_x;
    logic signed [SDW-1:0] da_y;
    logic signed [SDW-1:0] db_y;
  } qtr_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qtr_q_stat_t;

  function automatic logic signed [SDW-1:0] coord_diff(logic [CW-1:0] a, logic [CW-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

endpackage

### design/qtr_front.sv
// front end: takes requests, sorts corners, picks the triangle and its affine terms
module qtr_front #(
  parameter int MAX_WIDTH  = qtr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = qtr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  qtr_pkg::qtr_req_t                    req_i,
  output logic                                 busy_o,
  input  logic [qtr_pkg::DW-1:0]               w_i,
  input  logic [qtr_pkg::DW-1:0]               h_i,
  input  logic [qtr_pkg::PW-1:0]               wh_i,
  input  logic [qtr_pkg::CORNER_W-1:0]         corner_i [4],
  input  qtr_pkg::qtr_q_stat_t                 q_stat_i,
  output logic                                 push_o,
  output qtr_pkg::qtr_item_t                   item_o
);
  import qtr_pkg::*;

  logic          adv;
  logic          accept;

  logic          s1_valid_q;
  logic          s1_is_wr_q, s1_wr_en_q, s1_in_img_q;
  logic [CW-1:0] s1_x_q, s1_y_q;
  logic [RGB_W-1:0] s1_rgb_q;
  logic [PW-1:0] s1_xh_q, s1_yw_q, s1_wxh_q;

  logic      s2_valid_q;
  qtr_item_t s2_item_q, s2_item_d;

  logic [CW-1:0] px [4];
  logic [CW-1:0] py [4];

  assign adv    = !q_stat_i.full;
  assign busy_o = q_stat_i.full;
  assign accept = start_i && adv;

  // stable sort of the corners by x+y through ranks
  always_comb begin
    logic [CW:0] sum [4];
    logic [1:0]  rank [4];
    for (int i = 0; i < 4; i++) begin
      sum[i] = {1'b0, corner_i[i][CW-1:0]} + {1'b0, corner_i[i][2*CW-1:CW]};
    end
    for (int i = 0; i < 4; i++) begin
      rank[i] = 2'd0;
      for (int j = 0; j < 4; j++) begin
        if ((j < i && sum[j] <= sum[i]) || (j > i && sum[j] < sum[i])) begin
          rank[i] = rank[i] + 2'd1;
        end
      end
    end
    for (int k = 0; k < 4; k++) begin
      px[k] = '0;
      py[k] = '0;
      for (int i = 0; i < 4; i++) begin
        if (rank[i] == 2'(k)) begin
          px[k] = corner_i[i][CW-1:0];
          py[k] = corner_i[i][2*CW-1:CW];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_is_wr_q  <= (req_i.opcode == OP_WRITE);
      s1_wr_en_q  <= (int'(req_i.pixel_x) < MAX_WIDTH) && (int'(req_i.pixel_y) < MAX_HEIGHT);
      s1_in_img_q <= ({1'b0, req_i.pixel_x} < w_i) && ({1'b0, req_i.pixel_y} < h_i);
      s1_x_q      <= req_i.pixel_x;
      s1_y_q      <= req_i.pixel_y;
      s1_rgb_q    <= {req_i.red_in, req_i.green_in, req_i.blue_in};
      s1_xh_q     <= PW'(req_i.pixel_x) * PW'(h_i);
      s1_yw_q     <= PW'(req_i.pixel_y) * PW'(w_i);
      s1_wxh_q    <= PW'(w_i - {1'b0, req_i.pixel_x}) * PW'(h_i);
    end
    if (adv) begin
      s2_item_q <= s2_item_d;
    end
  end

  always_comb begin
    logic [PW:0]   t;
    logic [30:0]   lhs, lim_lo, lim_hi;
    logic [1:0]    tri_sel;
    t      = {1'b0, s1_xh_q} + {1'b0, s1_yw_q};
    lhs    = 31'(t) * 31'd1000;
    lim_lo = 31'(wh_i) * 31'd999;
    lim_hi = 31'(wh_i) * 31'd1001;
    if (s1_is_wr_q || !s1_in_img_q) begin
      tri_sel = TRI_NONE;
    end else if (lhs >= lim_lo) begin
      tri_sel = TRI_TWO;
    end else if (lhs <= lim_hi) begin
      tri_sel = TRI_ONE;
    end else begin
      tri_sel = TRI_NONE;
    end
    s2_item_d.is_wr   = s1_is_wr_q;
    s2_item_d.wr_en   = s1_wr_en_q;
    s2_item_d.tri_sel = tri_sel;
    s2_item_d.wr_x    = s1_x_q;
    s2_item_d.wr_y    = s1_y_q;
    s2_item_d.rgb     = s1_rgb_q;
    s2_item_d.mul_b   = s1_yw_q;
    if (tri_sel == TRI_TWO) begin
      s2_item_d.mul_a  = s1_wxh_q;
      s2_item_d.base_x = px[1];
      s2_item_d.base_y = py[1];
      s2_item_d.da_x   = coord_diff(px[2], px[3]);
      s2_item_d.db_x   = coord_diff(px[3], px[1]);
      s2_item_d.da_y   = coord_diff(py[2], py[3]);
      s2_item_d.db_y   = coord_diff(py[3], py[1]);
    end else begin
      s2_item_d.mul_a  = s1_xh_q;
      s2_item_d.base_x = px[0];
      s2_item_d.base_y = py[0];
      s2_item_d.da_x   = coord_diff(px[1], px[0]);
      s2_item_d.db_x   = coord_diff(px[2], px[0]);
      s2_item_d.da_y   = coord_diff(py[1], py[0]);
      s2_item_d.db_y   = coord_diff(py[2], py[0]);
    end
  end

  assign push_o = s2_valid_q && adv;
  assign item_o = s2_item_q;

endmodule

### design/qtr_queue.sv
// short queue between the front and the back
module qtr_queue #(
  parameter int DEPTH = qtr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  qtr_pkg::qtr_item_t   item_i,
  input  logic                 pop_i,
  output qtr_pkg::qtr_item_t   item_o,
  output qtr_pkg::qtr_q_stat_t stat_o
);
  import qtr_pkg::*;

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  qtr_item_t       slot_q [DEPTH];
  logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] count_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CNTW'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### design/qtr_back.sv
// back end: affine sums, pipelined divide, clamp and pixel store access
module qtr_back #(
  parameter int MAX_WIDTH  = qtr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = qtr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  qtr_pkg::qtr_q_stat_t   q_stat_i,
  input  qtr_pkg::qtr_item_t     item_i,
  output logic                   pop_o,
  input  logic [qtr_pkg::DW-1:0] w_i,
  input  logic [qtr_pkg::DW-1:0] h_i,
  input  logic [qtr_pkg::PW-1:0] wh_i,
  output logic                   result_valid_o,
  output qtr_pkg::qtr_res_t      result_o
);
  import qtr_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef struct packed {
    logic             is_wr;
    logic             wr_en;
    logic [1:0]       tri_sel;
    logic [CW-1:0]    wr_x;
    logic [CW-1:0]    wr_y;
    logic [RGB_W-1:0] rgb;
  } meta_t;

  // first back stage: products
  logic               b1_valid_q;
  meta_t              b1_meta_q;
  logic signed [30:0] b1_ax_q, b1_bx_q, b1_ay_q, b1_by_q;
  logic [28:0]        b1_cx_q, b1_cy_q;

  // divider stages, stage 0 holds the numerators
  logic          dv_valid_q [QW+1];
  meta_t         dv_meta_q  [QW+1];
  logic [NW-1:0] rx_q [QW+1];
  logic [NW-1:0] ry_q [QW+1];
  logic [QW-1:0] qx_q [QW+1];
  logic [QW-1:0] qy_q [QW+1];

  logic signed [NW-1:0] num_x, num_y;

  logic [RGB_W-1:0] mem_q [DEPTH];
  logic [RGB_W-1:0] rd_q;
  logic             m_valid_q;
  logic [1:0]       m_tri_q;
  logic             res_valid_q;
  qtr_res_t         res_q;

  logic [DW-1:0] sx, sy;
  logic [AW-1:0] addr;
  meta_t         last_meta;

  assign pop_o = !q_stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_meta_q <= '{is_wr: item_i.is_wr, wr_en: item_i.wr_en, tri_sel: item_i.tri_sel,
                   wr_x: item_i.wr_x, wr_y: item_i.wr_y, rgb: item_i.rgb};
    b1_ax_q <= item_i.da_x * $signed({1'b0, item_i.mul_a});
    b1_bx_q <= item_i.db_x * $signed({1'b0, item_i.mul_b});
    b1_ay_q <= item_i.da_y * $signed({1'b0, item_i.mul_a});
    b1_by_q <= item_i.db_y * $signed({1'b0, item_i.mul_b});
    b1_cx_q <= 29'(item_i.base_x) * 29'(wh_i);
    b1_cy_q <= 29'(item_i.base_y) * 29'(wh_i);
  end

  assign num_x = $signed({3'b0, b1_cx_q}) + $signed({b1_ax_q[30], b1_ax_q})
               + $signed({b1_bx_q[30], b1_bx_q});
  assign num_y = $signed({3'b0, b1_cy_q}) + $signed({b1_ay_q[30], b1_ay_q})
               + $signed({b1_by_q[30], b1_by_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q[0] <= 1'b0;
    end else begin
      dv_valid_q[0] <= b1_valid_q;
    end
  end

  // negative source coordinates clamp to zero
  always_ff @(posedge clk_i) begin
    dv_meta_q[0] <= b1_meta_q;
    rx_q[0]      <= num_x[NW-1] ? '0 : num_x;
    ry_q[0]      <= num_y[NW-1] ? '0 : num_y;
    qx_q[0]      <= '0;
    qy_q[0]      <= '0;
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [NW-1:0] dsh;
    assign dsh = NW'(wh_i) << (QW - 1 - k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[k+1] <= 1'b0;
      end else begin
        dv_valid_q[k+1] <= dv_valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_meta_q[k+1] <= dv_meta_q[k];
      if (rx_q[k] >= dsh) begin
        rx_q[k+1]            <= rx_q[k] - dsh;
        qx_q[k+1]            <= qx_q[k] | (QW'(1) << (QW - 1 - k));
      end else begin
        rx_q[k+1]            <= rx_q[k];
        qx_q[k+1]            <= qx_q[k];
      end
      if (ry_q[k] >= dsh) begin
        ry_q[k+1]            <= ry_q[k] - dsh;
        qy_q[k+1]            <= qy_q[k] | (QW'(1) << (QW - 1 - k));
      end else begin
        ry_q[k+1]            <= ry_q[k];
        qy_q[k+1]            <= qy_q[k];
      end
    end
  end

  assign last_meta = dv_meta_q[QW];

  always_comb begin
    logic [QW-1:0] wl, hl;
    wl = QW'(w_i) - QW'(1);
    hl = QW'(h_i) - QW'(1);
    sx = (qx_q[QW] > wl) ? DW'(wl) : DW'(qx_q[QW]);
    sy = (qy_q[QW] > hl) ? DW'(hl) : DW'(qy_q[QW]);
    if (last_meta.is_wr) begin
      addr = AW'(AW'(last_meta.wr_y) * AW'(MAX_WIDTH)) + AW'(last_meta.wr_x);
    end else begin
      addr = AW'(AW'(sy) * AW'(MAX_WIDTH)) + AW'(sx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_valid_q[QW] && last_meta.is_wr && last_meta.wr_en) begin
      mem_q[addr] <= last_meta.rgb;
    end
    rd_q    <= mem_q[addr];
    m_tri_q <= last_meta.tri_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      m_valid_q   <= dv_valid_q[QW] && !last_meta.is_wr;
      res_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_tri_q == TRI_NONE) begin
      res_q <= '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0, which_triangle: TRI_NONE};
    end else begin
      res_q <= '{red_out: rd_q[23:16], green_out: rd_q[15:8], blue_out: rd_q[7:0],
                 which_triangle: m_tri_q};
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

### design/quad_to_rect_affine_warp_core.sv
// quad to rectangle piecewise affine warp core, top level
// result path: a read's result strobe follows the front stages, the queue, the products,
//   the divider stages, the store read and the result register; writes give no result
// throughput: one request per cycle when not busy, set by the fully pipelined divider (one
//   quotient bit per stage) and the single store port, shared in order by writes and reads
// reset: asynchronous, active low; clears control state and the registers (corners to 0,
//   width and height to 512); the pixel store is not cleared, so no clearing pass is run
// the receiver cannot stall, so busy_o only reflects a full queue between front and back
module quad_to_rect_affine_warp_core #(
  parameter int MAX_WIDTH  = qtr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = qtr_pkg::MAX_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              start_i,
  input  qtr_pkg::qtr_req_t req_i,
  output logic              busy_o,
  // result strobe
  output logic              result_valid_o,
  output qtr_pkg::qtr_res_t result_o,
  // register write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [17:0]       cfg_data_i
);
  import qtr_pkg::*;

  logic [CORNER_W-1:0] corner_q [4];
  logic [DW-1:0]       cfg_w_q, cfg_h_q;
  logic [DW-1:0]       w_eff, h_eff;
  logic [PW-1:0]       wh_q;

  qtr_item_t   push_item, pop_item;
  logic        push, pop;
  qtr_q_stat_t q_stat;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        corner_q[i] <= '0;
      end
      cfg_w_q <= DIM_RESET;
      cfg_h_q <= DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CORNER_A:     corner_q[0] <= cfg_data_i;
        CFG_CORNER_B:     corner_q[1] <= cfg_data_i;
        CFG_CORNER_C:     corner_q[2] <= cfg_data_i;
        CFG_CORNER_D:     corner_q[3] <= cfg_data_i;
        CFG_IMAGE_WIDTH:  cfg_w_q     <= cfg_data_i[DW-1:0];
        CFG_IMAGE_HEIGHT: cfg_h_q     <= cfg_data_i[DW-1:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // zero size acts as one, oversize acts as the store limit
  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = DW'(1);
    end else if (int'(cfg_w_q) > MAX_WIDTH) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = cfg_w_q;
    end
    if (cfg_h_q == '0) begin
      h_eff = DW'(1);
    end else if (int'(cfg_h_q) > MAX_HEIGHT) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_h_q;
    end
  end

  // output area, first used in the front stage that follows request intake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wh_q <= '0;
    end else begin
      wh_q <= PW'(w_eff) * PW'(h_eff);
    end
  end

  // front: request intake, corner sort, triangle test, term selection
  qtr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .req_i    (req_i),
    .busy_o   (busy_o),
    .w_i      (w_eff),
    .h_i      (h_eff),
    .wh_i     (wh_q),
    .corner_i (corner_q),
    .q_stat_i (q_stat),
    .push_o   (push),
    .item_o   (push_item)
  );

  // decoupling queue
  qtr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (q_stat)
  );

  // back: products, divider, clamp, pixel store
  qtr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .item_i         (pop_item),
    .pop_o          (pop),
    .w_i            (w_eff),
    .h_i            (h_eff),
    .wh_i           (wh_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

### design/qtr_checker.sv
// port level checks of the warp core and their binding
`include "assert_macros.svh"

module qtr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input qtr_pkg::qtr_req_t req_i,
  input logic              busy_o,
  input logic              result_valid_o,
  input qtr_pkg::qtr_res_t result_o
);
  import qtr_pkg::*;

  logic rd_acc, wr_acc;
  logic lit_none;
  assign rd_acc = start_i && !busy_o && (req_i.opcode == OP_READ);
  assign wr_acc = start_i && !busy_o && (req_i.opcode == OP_WRITE);
  // a colored result that claims to lie in neither triangle
  assign lit_none = result_valid_o && (result_o.which_triangle == TRI_NONE) &&
                    ({result_o.red_out, result_o.green_out, result_o.blue_out} != '0);

  `QTR_ASSERT(a_read_gives_result, clk_i, rst_ni, rd_acc |-> ##18 result_valid_o)
  `QTR_ASSERT(a_write_gives_none, clk_i, rst_ni, wr_acc |-> ##18 !result_valid_o)
  `QTR_ASSERT(a_result_from_read, clk_i, rst_ni, result_valid_o |-> $past(rd_acc, 18))
  `QTR_ASSERT_NEVER(a_outside_is_black, clk_i, rst_ni, lit_none)

endmodule

bind quad_to_rect_affine_warp_core qtr_checker u_qtr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .req_i          (req_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
